// ===== sv/uart_8n1_with_fifos_top_defines.svh =====
// Assertion helpers shared by the UART block.
`ifndef UART_8N1_WITH_FIFOS_TOP_DEFINES_SVH
`define UART_8N1_WITH_FIFOS_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== sv/uart8n1_pkg.sv =====
package uart8n1_pkg;

   // FIFO geometry
   localparam int FIFO_DEPTH = 64;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int DATA_W     = 8;
   localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W + 1)'(FIFO_DEPTH);

   // Frame bit positions
   localparam int BIT_IDX_W = 4;
   localparam logic [BIT_IDX_W-1:0] FRAME_LAST_DATA = 4'd8;
   localparam logic [BIT_IDX_W-1:0] FRAME_STOP      = 4'd9;
   localparam logic [BIT_IDX_W-1:0] FRAME_END       = 4'd10;

   // Receive occupancy report
   localparam int COUNT_W = 6;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_EDGE  = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                rx_level;
      logic [DATA_W-1:0]   write_data;
   } req_type;

   typedef struct packed {
      logic                tx_level;
      logic [DATA_W-1:0]   read_data;
      logic                read_valid;
      logic                write_accepted;
      logic [COUNT_W-1:0]  rx_count;
      logic                tx_active;
      logic                rx_active;
   } rsp_type;

   // Advance a ring pointer, wrapping at the FIFO depth
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W:0] s;
      s = {1'b0, p} + 1'b1;
      ptr_next = (s >= DEPTH_EXT) ? '0 : s[PTR_W-1:0];
   endfunction

endpackage

// ===== sv/uart8n1_channel_if.sv =====
interface uart8n1_req_if;
   import uart8n1_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface uart8n1_rsp_if;
   import uart8n1_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/uart8n1_ram.sv =====
module uart8n1_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/uart_8n1_with_fifos_top.sv =====
// An accepted word's result is registered in the result stage once that is free.
// Throughput: one word per cycle while not stalled; each word is one pointer/shift
// update, and each FIFO RAM uses its single read port at most once per word.
// Reset (synchronous, active high) clears pointers, counters and flags and drives
// the transmit line high; FIFO RAM contents are not cleared and need no sweep.
`include "uart_8n1_with_fifos_top_defines.svh"

module uart_8n1_with_fifos_top (
   input  logic          clock,
   input  logic          reset,
   uart8n1_req_if.sink   req_bus,
   uart8n1_rsp_if.source rsp_bus
);
   import uart8n1_pkg::*;

   // Input stage
   req_type            in_ff;
   logic               in_valid_ff, in_valid_in;
   logic               req_accept;
   logic               advance;

   // FIFO pointers
   logic [PTR_W-1:0]   tx_w_ff, tx_w_in, tx_r_ff, tx_r_in;
   logic [PTR_W-1:0]   rx_w_ff, rx_w_in, rx_r_ff, rx_r_in;
   logic [PTR_W-1:0]   tx_w_next, tx_r_next, rx_w_next, rx_r_next;

   // Transmitter
   logic [DATA_W-1:0]    tx_shift_ff, tx_shift_in, tx_shift_eff;
   logic                 tx_fetch_ff, tx_fetch_in;
   logic [BIT_IDX_W-1:0] tx_idx_ff, tx_idx_in;
   logic                 tx_busy_ff, tx_busy_in;
   logic                 line_ff, line_in;
   logic                 tx_avail;
   logic                 tx_load_go, tx_load_bypass;
   logic [2:0]           tx_sel;

   // Receiver
   logic [DATA_W-1:0]    rx_shift_ff, rx_shift_in;
   logic [BIT_IDX_W-1:0] rx_idx_ff, rx_idx_in;
   logic                 rx_busy_ff, rx_busy_in;
   logic [2:0]           rx_sel;

   // RAM ports
   logic                 tx_we, tx_re, rx_we, rx_re;
   logic [DATA_W-1:0]    tx_rdata, rx_rdata;

   // Result stage
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rvalid_ff, rvalid_in;
   logic                 waccept_ff, waccept_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [PTR_W:0]       rx_occ;

   // Handshake: the input stage moves on whenever the result slot is free
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !reset && (!in_valid_ff || advance);
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   assign tx_w_next = ptr_next(tx_w_ff);
   assign tx_r_next = ptr_next(tx_r_ff);
   assign rx_w_next = ptr_next(rx_w_ff);
   assign rx_r_next = ptr_next(rx_r_ff);
   assign tx_avail  = (tx_w_ff != tx_r_ff);

   // A byte fetched from the transmit RAM lands in the cycle after the load
   assign tx_shift_eff = tx_fetch_ff ? tx_rdata : tx_shift_ff;

   // Per-word state update
   always_comb begin
      tx_w_in        = tx_w_ff;
      tx_r_in        = tx_r_ff;
      rx_w_in        = rx_w_ff;
      rx_r_in        = rx_r_ff;
      tx_shift_in    = tx_shift_eff;
      tx_fetch_in    = 1'b0;
      tx_idx_in      = tx_idx_ff;
      tx_busy_in     = tx_busy_ff;
      line_in        = line_ff;
      rx_shift_in    = rx_shift_ff;
      rx_idx_in      = rx_idx_ff;
      rx_busy_in     = rx_busy_ff;
      tx_we          = 1'b0;
      tx_re          = 1'b0;
      rx_we          = 1'b0;
      rx_re          = 1'b0;
      rvalid_in      = 1'b0;
      waccept_in     = 1'b0;
      tx_load_go     = 1'b0;
      tx_load_bypass = 1'b0;
      tx_sel         = '0;
      rx_sel         = '0;

      if (advance) begin
         unique case (in_ff.op)
            OP_TICK: begin
               if (rx_busy_ff) begin
                  // Sample a data bit, or close the frame and push the byte if the FIFO has room
                  rx_idx_in = rx_idx_ff + 1'b1;
                  rx_sel    = 3'(rx_idx_in - 1'b1);
                  if (rx_idx_in >= 4'd1 && rx_idx_in <= FRAME_LAST_DATA) begin
                     rx_shift_in[rx_sel] = in_ff.rx_level;
                  end else if (rx_idx_in >= FRAME_END) begin
                     rx_busy_in = 1'b0;
                     rx_idx_in  = '0;
                     if (rx_w_next != rx_r_ff) begin
                        rx_we   = 1'b1;
                        rx_w_in = rx_w_next;
                     end
                  end
               end else if (tx_busy_ff) begin
                  // Drive start, data or stop; reload at frame end
                  tx_idx_in = tx_idx_ff + 1'b1;
                  tx_sel    = 3'(tx_idx_ff - 1'b1);
                  priority if (tx_idx_ff == '0) begin
                     line_in = 1'b0;
                  end else if (tx_idx_ff <= FRAME_LAST_DATA) begin
                     line_in = tx_shift_eff[tx_sel];
                  end else if (tx_idx_ff == FRAME_STOP) begin
                     line_in = 1'b1;
                  end else if (tx_idx_ff == FRAME_END) begin
                     tx_busy_in = 1'b0;
                     tx_load_go = tx_avail;
                  end
               end else begin
                  tx_load_go = tx_avail;
               end
            end
            OP_EDGE: begin
               if (!rx_busy_ff) begin
                  rx_busy_in  = 1'b1;
                  rx_idx_in   = '0;
                  rx_shift_in = '0;
               end
            end
            OP_WRITE: begin
               if (tx_w_next != tx_r_ff) begin
                  tx_we      = 1'b1;
                  tx_w_in    = tx_w_next;
                  waccept_in = 1'b1;
               end
               // An empty FIFO hands the new byte straight to the shifter
               if (!tx_busy_ff && (tx_avail || waccept_in)) begin
                  tx_load_go     = 1'b1;
                  tx_load_bypass = !tx_avail;
               end
            end
            OP_READ: begin
               if (rx_w_ff != rx_r_ff) begin
                  rx_re     = 1'b1;
                  rx_r_in   = rx_r_next;
                  rvalid_in = 1'b1;
               end
            end
         endcase

         // Load the next queued byte into the transmitter
         if (tx_load_go) begin
            tx_idx_in  = '0;
            tx_busy_in = 1'b1;
            tx_r_in    = tx_r_next;
            if (tx_load_bypass) begin
               tx_shift_in = in_ff.write_data;
            end else begin
               tx_re       = 1'b1;
               tx_fetch_in = 1'b1;
            end
         end
      end
   end

   // Receive occupancy after the word, saturated to the report width
   always_comb begin
      if (rx_w_in >= rx_r_in) begin
         rx_occ = {1'b0, rx_w_in} - {1'b0, rx_r_in};
      end else begin
         rx_occ = {1'b0, rx_w_in} + DEPTH_EXT - {1'b0, rx_r_in};
      end
      if (32'(rx_occ) > 32'(COUNT_MAX)) begin
         count_in = COUNT_MAX;
      end else begin
         count_in = COUNT_W'(rx_occ);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tx_w_ff      <= '0;
         tx_r_ff      <= '0;
         rx_w_ff      <= '0;
         rx_r_ff      <= '0;
         tx_fetch_ff  <= 1'b0;
         tx_idx_ff    <= '0;
         tx_busy_ff   <= 1'b0;
         line_ff      <= 1'b1;
         rx_idx_ff    <= '0;
         rx_busy_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         tx_w_ff      <= tx_w_in;
         tx_r_ff      <= tx_r_in;
         rx_w_ff      <= rx_w_in;
         rx_r_ff      <= rx_r_in;
         tx_fetch_ff  <= tx_fetch_in;
         tx_idx_ff    <= tx_idx_in;
         tx_busy_ff   <= tx_busy_in;
         line_ff      <= line_in;
         rx_idx_ff    <= rx_idx_in;
         rx_busy_ff   <= rx_busy_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= req_bus.data;
      end
      if (advance) begin
         rvalid_ff  <= rvalid_in;
         waccept_ff <= waccept_in;
         count_ff   <= count_in;
      end
      tx_shift_ff <= tx_shift_in;
      rx_shift_ff <= rx_shift_in;
   end

   // FIFO storage
   uart8n1_ram #(
      .WIDTH (DATA_W),
      .DEPTH (FIFO_DEPTH)
   ) u_tx_ram (
      .clock (clock),
      .we    (tx_we),
      .waddr (tx_w_ff),
      .wdata (in_ff.write_data),
      .re    (tx_re),
      .raddr (tx_r_ff),
      .rdata (tx_rdata)
   );

   uart8n1_ram #(
      .WIDTH (DATA_W),
      .DEPTH (FIFO_DEPTH)
   ) u_rx_ram (
      .clock (clock),
      .we    (rx_we),
      .waddr (rx_w_ff),
      .wdata (rx_shift_ff),
      .re    (rx_re),
      .raddr (rx_r_ff),
      .rdata (rx_rdata)
   );

   // Result word; the popped byte comes straight from the RAM's read register
   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.data.tx_level       = line_ff;
   assign rsp_bus.data.read_data      = rvalid_ff ? rx_rdata : '0;
   assign rsp_bus.data.read_valid     = rvalid_ff;
   assign rsp_bus.data.write_accepted = waccept_ff;
   assign rsp_bus.data.rx_count       = count_ff;
   assign rsp_bus.data.tx_active      = tx_busy_ff;
   assign rsp_bus.data.rx_active      = rx_busy_ff;

   `ASSERT_IMPL(a_fetch_while_busy, clock, reset, tx_fetch_ff, tx_busy_ff)
   `ASSERT_IMPL(a_rsp_one_kind, clock, reset, rsp_valid_ff, !(rvalid_ff && waccept_ff))
   `ASSERT_IMPL(a_rx_idx_range, clock, reset, rx_busy_ff, rx_idx_ff < FRAME_END)
   `ASSERT_IMPL(a_tx_idx_range, clock, reset, tx_busy_ff, tx_idx_ff <= FRAME_END)
   `ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_ff))

endmodule
